// File: rtl/env_sensor_compensation_unit_defines.svh
// Assertion helpers shared by the compensation unit.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ESC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ESC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/esc_pkg.sv
package esc_pkg;

   localparam int FRONT_STAGES = 12;
   localparam int DIV_STAGES   = 32;

   localparam logic [31:0] T_OFFSET_P   = 32'd64000;
   localparam logic [31:0] T_OFFSET_H   = 32'd76800;
   localparam logic [31:0] HUM_MAX      = 32'd419430400;
   localparam logic [31:0] P_BASE       = 32'd1048576;
   localparam logic [31:0] P_SCALE      = 32'd3125;
   localparam logic [31:0] P_ROUND      = 32'd32768;
   localparam logic [31:0] H_ROUND_B    = 32'd16384;
   localparam logic [31:0] H_OFFSET_D   = 32'd2097152;
   localparam logic [31:0] H_ROUND_D    = 32'd8192;
   localparam logic [31:0] PRESS_MAX    = 32'd262143;

   typedef enum logic [2:0] {
      CSR_TEMP_TRIM    = 3'd0,
      CSR_PRESS_TRIM_A = 3'd1,
      CSR_PRESS_TRIM_B = 3'd2,
      CSR_PRESS_TRIM_C = 3'd3,
      CSR_HUM_TRIM_A   = 3'd4,
      CSR_HUM_TRIM_B   = 3'd5
   } esc_csr_type;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } esc_req_type;

   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic [17:0]        pressure_pa;
      logic               pressure_div_zero;
      logic [16:0]        humidity_q10;
   } esc_rsp_type;

   typedef struct packed {
      logic [47:0] temp_trim;
      logic [47:0] press_trim_a;
      logic [47:0] press_trim_b;
      logic [47:0] press_trim_c;
      logic [31:0] hum_trim_a;
      logic [31:0] hum_trim_b;
   } esc_trim_type;

   // results that ride alongside the pressure division
   typedef struct packed {
      logic signed [15:0] temp_centi;
      logic [16:0]        hum_q10;
      logic               div_zero;
      logic               half;
   } esc_side_type;

   function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
      logic signed [31:0] s;
      s = $signed(v);
      return 32'(s >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

// File: rtl/esc_front.sv
module esc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  esc_pkg::esc_req_type in_data,
   input  esc_pkg::esc_trim_type trim,
   output logic                 out_vld,
   output logic [31:0]          out_num,
   output logic [31:0]          out_den,
   output esc_pkg::esc_side_type out_side
);
   import esc_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
   logic [31:0] adc_t, d0;

   logic [31:0] s1_ta_ff, s1_dd_ff;
   logic [19:0] s1_adcp_ff, s2_adcp_ff, s3_adcp_ff, s4_adcp_ff, s5_adcp_ff, s6_adcp_ff;
   logic [19:0] s7_adcp_ff;
   logic [15:0] s1_adch_ff, s2_adch_ff, s3_adch_ff, s4_adch_ff, s5_adch_ff;
   logic [31:0] s2_a_ff, s2_x_ff;
   logic [31:0] s3_tf_ff;
   logic signed [15:0] s4_temp_ff, s5_temp_ff, s6_temp_ff, s7_temp_ff, s8_temp_ff;
   logic signed [15:0] s9_temp_ff, s10_temp_ff, s11_temp_ff, s12_temp_ff;
   logic [31:0] s4_pa_ff, s4_pd_ff, s4_ha_ff;
   logic [31:0] s5_pdd_ff, s5_pa5_ff, s5_pa2_ff, s5_h5a_ff, s5_h6a_ff, s5_h3a_ff;
   logic [31:0] s6_b1_ff, s6_p3m_ff, s6_pa5_ff, s6_pa2_ff, s6_hb_ff, s6_hd1_ff;
   logic [31:0] s7_pb_ff, s7_pa_ff, s7_hd2_ff, s7_hb_ff;
   logic [31:0] s8_pa_ff, s8_pn_ff, s8_hd3_ff, s8_hb_ff;
   logic [31:0] s9_den_ff, s9_pn_ff, s9_hv_ff;
   logic [31:0] s10_num_ff, s10_den_ff, s10_sq_ff, s10_hv_ff;
   logic        s10_half_ff, s10_dz_ff;
   logic [31:0] s11_num_ff, s11_den_ff, s11_hq_ff, s11_hv_ff;
   logic        s11_half_ff, s11_dz_ff;
   logic [31:0] s12_num_ff, s12_den_ff;
   logic        s12_half_ff, s12_dz_ff;
   logic [16:0] s12_hum_ff;

   logic [31:0] temp_in, pa_in, hs15, hv2_in, hcl_in, tmp_sat;
   logic signed [15:0] temp_sat_in;

   always_comb begin
      t1 = {16'd0, trim.temp_trim[15:0]};
      t2 = sx16(trim.temp_trim[31:16]);
      t3 = sx16(trim.temp_trim[47:32]);
      p1 = {16'd0, trim.press_trim_a[15:0]};
      p2 = sx16(trim.press_trim_a[31:16]);
      p3 = sx16(trim.press_trim_a[47:32]);
      p4 = sx16(trim.press_trim_b[15:0]);
      p5 = sx16(trim.press_trim_b[31:16]);
      p6 = sx16(trim.press_trim_b[47:32]);
      h1 = {24'd0, trim.hum_trim_a[7:0]};
      h2 = sx16(trim.hum_trim_a[23:8]);
      h3 = {24'd0, trim.hum_trim_a[31:24]};
      h4 = sx12(trim.hum_trim_b[11:0]);
      h5 = sx12(trim.hum_trim_b[23:12]);
      h6 = sx8(trim.hum_trim_b[31:24]);
      adc_t = {12'd0, in_data.raw_temperature};
      d0 = (adc_t >> 4) - t1;
   end

   always_comb begin
      temp_in = sra32(s3_tf_ff * 32'd5 + 32'd128, 8);
      if ($signed(temp_in) < -32'sd32768) begin
         temp_sat_in = -16'sd32768;
      end else if ($signed(temp_in) > 32'sd32767) begin
         temp_sat_in = 16'sd32767;
      end else begin
         temp_sat_in = $signed(temp_in[15:0]);
      end
      pa_in = sra32(s3_tf_ff, 1) - T_OFFSET_P;
      hs15 = sra32(s9_hv_ff, 15);
      hv2_in = s11_hv_ff - sra32(s11_hq_ff, 4);
      if (hv2_in[31]) begin
         hcl_in = 32'd0;
      end else if (hv2_in > HUM_MAX) begin
         hcl_in = HUM_MAX;
      end else begin
         hcl_in = hv2_in;
      end
      tmp_sat = hcl_in >> 12;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // temperature, pressure and humidity terms
         s1_ta_ff   <= ((adc_t >> 3) - (t1 << 1)) * t2;
         s1_dd_ff   <= d0 * d0;
         s1_adcp_ff <= in_data.raw_pressure;
         s1_adch_ff <= in_data.raw_humidity;

         s2_a_ff    <= sra32(s1_ta_ff, 11);
         s2_x_ff    <= sra32(s1_dd_ff, 12) * t3;
         s2_adcp_ff <= s1_adcp_ff;
         s2_adch_ff <= s1_adch_ff;

         s3_tf_ff   <= s2_a_ff + sra32(s2_x_ff, 14);
         s3_adcp_ff <= s2_adcp_ff;
         s3_adch_ff <= s2_adch_ff;

         s4_temp_ff <= temp_sat_in;
         s4_pa_ff   <= pa_in;
         s4_pd_ff   <= sra32(pa_in, 2);
         s4_ha_ff   <= s3_tf_ff - T_OFFSET_H;
         s4_adcp_ff <= s3_adcp_ff;
         s4_adch_ff <= s3_adch_ff;

         s5_pdd_ff  <= s4_pd_ff * s4_pd_ff;
         s5_pa5_ff  <= s4_pa_ff * p5;
         s5_pa2_ff  <= s4_pa_ff * p2;
         s5_h5a_ff  <= h5 * s4_ha_ff;
         s5_h6a_ff  <= s4_ha_ff * h6;
         s5_h3a_ff  <= s4_ha_ff * h3;
         s5_temp_ff <= s4_temp_ff;
         s5_adcp_ff <= s4_adcp_ff;
         s5_adch_ff <= s4_adch_ff;

         s6_b1_ff   <= sra32(s5_pdd_ff, 11) * p6;
         s6_p3m_ff  <= p3 * sra32(s5_pdd_ff, 13);
         s6_pa5_ff  <= s5_pa5_ff << 1;
         s6_pa2_ff  <= s5_pa2_ff;
         s6_hb_ff   <= sra32(({16'd0, s5_adch_ff} << 14) - (h4 << 20) - s5_h5a_ff
                             + H_ROUND_B, 15);
         s6_hd1_ff  <= sra32(s5_h6a_ff, 10) * (sra32(s5_h3a_ff, 11) + P_ROUND);
         s6_temp_ff <= s5_temp_ff;
         s6_adcp_ff <= s5_adcp_ff;

         s7_pb_ff   <= sra32(s6_b1_ff + s6_pa5_ff, 2) + (p4 << 16);
         s7_pa_ff   <= sra32(sra32(s6_p3m_ff, 3) + sra32(s6_pa2_ff, 1), 18);
         s7_hd2_ff  <= (sra32(s6_hd1_ff, 10) + H_OFFSET_D) * h2;
         s7_hb_ff   <= s6_hb_ff;
         s7_temp_ff <= s6_temp_ff;
         s7_adcp_ff <= s6_adcp_ff;

         s8_pa_ff   <= (P_ROUND + s7_pa_ff) * p1;
         s8_pn_ff   <= (P_BASE - {12'd0, s7_adcp_ff}) - sra32(s7_pb_ff, 12);
         s8_hd3_ff  <= sra32(s7_hd2_ff + H_ROUND_D, 14);
         s8_hb_ff   <= s7_hb_ff;
         s8_temp_ff <= s7_temp_ff;

         s9_den_ff  <= sra32(s8_pa_ff, 15);
         s9_pn_ff   <= s8_pn_ff * P_SCALE;
         s9_hv_ff   <= s8_hb_ff * s8_hd3_ff;
         s9_temp_ff <= s8_temp_ff;

         // a top bit set in the dividend: divide first, double after
         s10_half_ff <= s9_pn_ff[31];
         s10_num_ff  <= s9_pn_ff[31] ? s9_pn_ff : (s9_pn_ff << 1);
         s10_den_ff  <= s9_den_ff;
         s10_dz_ff   <= (s9_den_ff == 32'd0);
         s10_sq_ff   <= hs15 * hs15;
         s10_hv_ff   <= s9_hv_ff;
         s10_temp_ff <= s9_temp_ff;

         s11_hq_ff   <= sra32(s10_sq_ff, 7) * h1;
         s11_hv_ff   <= s10_hv_ff;
         s11_num_ff  <= s10_num_ff;
         s11_den_ff  <= s10_den_ff;
         s11_half_ff <= s10_half_ff;
         s11_dz_ff   <= s10_dz_ff;
         s11_temp_ff <= s10_temp_ff;

         s12_hum_ff  <= tmp_sat[16:0];
         s12_num_ff  <= s11_num_ff;
         s12_den_ff  <= s11_den_ff;
         s12_half_ff <= s11_half_ff;
         s12_dz_ff   <= s11_dz_ff;
         s12_temp_ff <= s11_temp_ff;
      end
   end

   assign out_vld = vld_ff[FRONT_STAGES-1];
   assign out_num = s12_num_ff;
   assign out_den = s12_den_ff;
   always_comb begin
      out_side.temp_centi = s12_temp_ff;
      out_side.hum_q10    = s12_hum_ff;
      out_side.div_zero   = s12_dz_ff;
      out_side.half       = s12_half_ff;
   end

endmodule

// File: rtl/esc_div.sv
module esc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [31:0]           in_num,
   input  logic [31:0]           in_den,
   input  esc_pkg::esc_side_type in_side,
   output logic                  out_vld,
   output logic [31:0]           out_quo,
   output esc_pkg::esc_side_type out_side
);
   import esc_pkg::*;

   // one quotient bit per stage, restoring
   logic [DIV_STAGES-1:0] vld_ff;
   logic [31:0]           rem_ff [DIV_STAGES];
   logic [31:0]           nq_ff  [DIV_STAGES];
   logic [31:0]           den_ff [DIV_STAGES];
   esc_side_type          side_ff [DIV_STAGES];

   logic [31:0]  rem_in [DIV_STAGES];
   logic [31:0]  nq_in  [DIV_STAGES];
   logic [31:0]  den_in [DIV_STAGES];
   esc_side_type side_in [DIV_STAGES];

   always_comb begin
      logic [31:0]  rem_src, nq_src, den_src;
      logic [32:0]  trial;
      logic         ge;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            rem_src    = 32'd0;
            nq_src     = in_num;
            den_src    = in_den;
            side_in[k] = in_side;
         end else begin
            rem_src    = rem_ff[k-1];
            nq_src     = nq_ff[k-1];
            den_src    = den_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         trial     = {rem_src, nq_src[31]};
         ge        = (trial >= {1'b0, den_src});
         rem_in[k] = ge ? 32'(trial - {1'b0, den_src}) : trial[31:0];
         nq_in[k]  = {nq_src[30:0], ge};
         den_in[k] = den_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES-1];
   assign out_quo  = nq_ff[DIV_STAGES-1];
   assign out_side = side_ff[DIV_STAGES-1];

endmodule

// File: rtl/esc_back.sv
module esc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [31:0]           in_quo,
   input  esc_pkg::esc_side_type in_side,
   input  esc_pkg::esc_trim_type trim,
   output logic                  out_vld,
   output esc_pkg::esc_rsp_type  out_data
);
   import esc_pkg::*;

   logic [31:0] p7, p8, p9, p_in, fin, sum;
   logic [31:0] b1_p_ff, b1_sq_ff, b1_pb_ff;
   logic [31:0] b2_p_ff, b2_a_ff, b2_b_ff;
   esc_side_type b1_side_ff, b2_side_ff;
   logic [1:0] vld_ff;
   logic out_vld_ff;
   esc_rsp_type out_data_ff, out_data_in;

   always_comb begin
      p7   = sx16(trim.press_trim_c[15:0]);
      p8   = sx16(trim.press_trim_c[31:16]);
      p9   = sx16(trim.press_trim_c[47:32]);
      p_in = in_side.half ? (in_quo << 1) : in_quo;
      sum  = b2_a_ff + b2_b_ff + p7;
      fin  = b2_p_ff + sra32(sum, 4);
      out_data_in.temperature_centi = b2_side_ff.temp_centi;
      out_data_in.humidity_q10      = b2_side_ff.hum_q10;
      out_data_in.pressure_div_zero = b2_side_ff.div_zero;
      if (b2_side_ff.div_zero || fin[31]) begin
         out_data_in.pressure_pa = 18'd0;
      end else if (fin > PRESS_MAX) begin
         out_data_in.pressure_pa = PRESS_MAX[17:0];
      end else begin
         out_data_in.pressure_pa = fin[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[0], in_vld};
         out_vld_ff <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_p_ff    <= p_in;
         b1_sq_ff   <= (p_in >> 3) * (p_in >> 3);
         b1_pb_ff   <= (p_in >> 2) * p8;
         b1_side_ff <= in_side;

         b2_a_ff    <= sra32(p9 * (b1_sq_ff >> 13), 12);
         b2_b_ff    <= sra32(b1_pb_ff, 13);
         b2_p_ff    <= b1_p_ff;
         b2_side_ff <= b1_side_ff;

         out_data_ff <= out_data_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_data = out_data_ff;

endmodule

// File: rtl/env_sensor_compensation_unit.sv
// Environmental sensor compensation unit.
// Request channel (req_valid/req_ready/req_data) takes one set of raw
// pressure, temperature and humidity readings per item. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns temperature in 0.01 degC, pressure
// in Pa with a divide-by-zero flag, and humidity in 1/1024 %RH.
// Trim coefficients are written through csr_wr_en/csr_index/csr_wdata; the
// user must write them only while no item is in flight, which the block
// does not enforce; writes to unused indexes are dropped. The pipe has 12
// arithmetic stages, a 32-stage pressure divider retiring one quotient bit
// per stage, and 3 post-division stages ending in the response register.
// Throughput is one item per cycle while the response is not stalled; every
// stage holds a 32x32 multiply or one divider step at most.
// A stalled response (rsp_valid high, rsp_ready low) freezes the whole pipe
// and drops req_ready; nothing is lost or duplicated. Bubbles ahead of the
// response register keep filling while the pipe runs.
// Synchronous reset clears all valid bits and zeroes the trim registers.
`include "env_sensor_compensation_unit_defines.svh"

module env_sensor_compensation_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  esc_pkg::esc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output esc_pkg::esc_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [47:0]          csr_wdata
);
   import esc_pkg::*;

   esc_trim_type trim_ff;
   logic         en;
   logic         f_vld, d_vld;
   logic [31:0]  f_num, f_den, d_quo;
   esc_side_type f_side, d_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEMP_TRIM:    trim_ff.temp_trim    <= csr_wdata;
            CSR_PRESS_TRIM_A: trim_ff.press_trim_a <= csr_wdata;
            CSR_PRESS_TRIM_B: trim_ff.press_trim_b <= csr_wdata;
            CSR_PRESS_TRIM_C: trim_ff.press_trim_c <= csr_wdata;
            CSR_HUM_TRIM_A:   trim_ff.hum_trim_a   <= csr_wdata[31:0];
            CSR_HUM_TRIM_B:   trim_ff.hum_trim_b   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipe unless the response register is blocked
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .trim     (trim_ff),
      .out_vld  (f_vld),
      .out_num  (f_num),
      .out_den  (f_den),
      .out_side (f_side)
   );

   esc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (f_vld),
      .in_num   (f_num),
      .in_den   (f_den),
      .in_side  (f_side),
      .out_vld  (d_vld),
      .out_quo  (d_quo),
      .out_side (d_side)
   );

   esc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (d_vld),
      .in_quo   (d_quo),
      .in_side  (d_side),
      .trim     (trim_ff),
      .out_vld  (rsp_valid),
      .out_data (rsp_data)
   );

   `ESC_ASSERT_IMPLY(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)
   `ESC_ASSERT_IMPLY(a_div_zero_press, rsp_valid && rsp_data.pressure_div_zero, rsp_data.pressure_pa == 18'd0)
   `ESC_ASSERT_IMPLY(a_hum_range, rsp_valid, rsp_data.humidity_q10 <= 17'd102400)
   `ESC_ASSERT_NEXT(a_stall_holds_rsp, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

// File: tb/sv/env_sensor_compensation_unit_tb.sv
module env_sensor_compensation_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import esc_pkg::*;

   localparam int LATENCY     = 47;
   localparam int WDOG_LIMIT  = 20000;
   localparam int MAX_REPORTS = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   esc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   esc_rsp_type rsp_data;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;

   env_sensor_compensation_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the trim registers
   logic [47:0] trim_t, trim_pa, trim_pb, trim_pc;
   logic [31:0] trim_ha, trim_hb;

   esc_rsp_type expected_readings[$];
   int          mismatch_count;
   int          readings_sent;
   int          readings_checked;
   int          div_zero_seen;
   int          idle_cycles;
   bit          sender_idle_en;
   bit          receiver_idle_en;
   bit          receiver_hold;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] asr(input logic [31:0] v, input int n);
      logic signed [31:0] s;
      s = v;
      return s >>> n;
   endfunction

   function automatic logic [31:0] sext(input logic [47:0] r, input int pos, input int bits);
      logic [31:0] v;
      logic [31:0] m;
      m = (32'd1 << bits) - 32'd1;
      v = 32'(r >> pos) & m;
      if (v[bits-1]) begin
         v = v | ~m;
      end
      return v;
   endfunction

   function automatic esc_rsp_type compensate(input esc_req_type rq);
      logic [31:0] adc_p, adc_t, adc_h;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, d, p, t_fine, hv, tv;
      logic signed [31:0] ts;
      esc_rsp_type r;
      adc_p = {12'd0, rq.raw_pressure};
      adc_t = {12'd0, rq.raw_temperature};
      adc_h = {16'd0, rq.raw_humidity};
      t1 = {16'd0, trim_t[15:0]};
      t2 = sext(trim_t, 16, 16);
      t3 = sext(trim_t, 32, 16);
      p1 = {16'd0, trim_pa[15:0]};
      p2 = sext(trim_pa, 16, 16);
      p3 = sext(trim_pa, 32, 16);
      p4 = sext(trim_pb, 0, 16);
      p5 = sext(trim_pb, 16, 16);
      p6 = sext(trim_pb, 32, 16);
      p7 = sext(trim_pc, 0, 16);
      p8 = sext(trim_pc, 16, 16);
      p9 = sext(trim_pc, 32, 16);
      h1 = {24'd0, trim_ha[7:0]};
      h2 = sext({16'd0, trim_ha}, 8, 16);
      h3 = {24'd0, trim_ha[31:24]};
      h4 = sext({16'd0, trim_hb}, 0, 12);
      h5 = sext({16'd0, trim_hb}, 12, 12);
      h6 = sext({16'd0, trim_hb}, 24, 8);

      a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      t_fine = a + b;
      tv = asr(t_fine * 32'd5 + 32'd128, 8);
      ts = tv;
      if (ts < -32768) begin
         r.temperature_centi = 16'h8000;
      end else if (ts > 32767) begin
         r.temperature_centi = 16'h7fff;
      end else begin
         r.temperature_centi = tv[15:0];
      end

      a = asr(t_fine, 1) - 32'd64000;
      d = asr(a, 2);
      b = asr(d * d, 11) * p6;
      b = b + ((a * p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(p3 * asr(d * d, 13), 3) + asr(p2 * a, 1), 18);
      a = asr((32'd32768 + a) * p1, 15);
      if (a == 32'd0) begin
         r.pressure_div_zero = 1'b1;
         r.pressure_pa = '0;
      end else begin
         r.pressure_div_zero = 1'b0;
         p = ((32'd1048576 - adc_p) - asr(b, 12)) * 32'd3125;
         if (p < 32'h80000000) begin
            p = (p << 1) / a;
         end else begin
            p = (p / a) * 32'd2;
         end
         a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = asr((p >> 2) * p8, 13);
         p = p + asr(a + b + p7, 4);
         ts = p;
         if (ts < 0) begin
            r.pressure_pa = '0;
         end else if (ts > 262143) begin
            r.pressure_pa = 18'h3ffff;
         end else begin
            r.pressure_pa = p[17:0];
         end
      end

      a = t_fine - 32'd76800;
      b = asr((adc_h << 14) - (h4 << 20) - (h5 * a) + 32'd16384, 15);
      d = asr(asr(a * h6, 10) * (asr(a * h3, 11) + 32'd32768), 10) + 32'd2097152;
      d = asr(d * h2 + 32'd8192, 14);
      hv = b * d;
      hv = hv - asr(asr(asr(hv, 15) * asr(hv, 15), 7) * h1, 4);
      ts = hv;
      if (ts < 0) begin
         hv = 32'd0;
      end else if (ts > 419430400) begin
         hv = 32'd419430400;
      end
      r.humidity_q10 = hv[28:12];
      return r;
   endfunction

   task automatic write_trim(input esc_csr_type idx, input logic [47:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TEMP_TRIM:    trim_t  = value;
         CSR_PRESS_TRIM_A: trim_pa = value;
         CSR_PRESS_TRIM_B: trim_pb = value;
         CSR_PRESS_TRIM_C: trim_pc = value;
         CSR_HUM_TRIM_A:   trim_ha = value[31:0];
         CSR_HUM_TRIM_B:   trim_hb = value[31:0];
         default: ;
      endcase
   endtask

   // write all six registers; caller guarantees the pipe is empty
   task automatic load_trims(input logic [47:0] tt, input logic [47:0] pa,
                             input logic [47:0] pb, input logic [47:0] pc,
                             input logic [31:0] ha, input logic [31:0] hb);
      write_trim(CSR_TEMP_TRIM, tt);
      write_trim(CSR_PRESS_TRIM_A, pa);
      write_trim(CSR_PRESS_TRIM_B, pb);
      write_trim(CSR_PRESS_TRIM_C, pc);
      write_trim(CSR_HUM_TRIM_A, {16'hdead, ha});
      write_trim(CSR_HUM_TRIM_B, {16'hbeef, hb});
      csr_wr_en <= 1'b0;
   endtask

   // valid stays high between back-to-back items; drop it only while idling
   task automatic send_reading(input esc_req_type rq);
      while (sender_idle_en && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      expected_readings.push_back(compensate(rq));
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      readings_sent++;
   endtask

   task automatic send_random(input int n);
      esc_req_type rq;
      repeat (n) begin
         rq.raw_pressure    = 20'($urandom);
         rq.raw_temperature = 20'($urandom);
         rq.raw_humidity    = 16'($urandom);
         // most readings near real sensor values, rest full range
         if ($urandom_range(3) != 0) begin
            rq.raw_pressure    = 20'($urandom_range(300000, 660000));
            rq.raw_temperature = 20'($urandom_range(400000, 640000));
            rq.raw_humidity    = 16'($urandom_range(20000, 40000));
         end
         send_reading(rq);
      end
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_trims();
      load_trims(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 $urandom, $urandom);
   endtask

   // typical factory trim set, gives realistic readings
   task automatic typical_trims();
      load_trims({16'd50, 16'd26435, 16'd27504}, {16'd3024, 16'hd67d, 16'd36477},
                 {16'hfff9, 16'h0d4c, 16'd2855}, {16'd6000, 16'hd0a8, 16'd140},
                 {8'd0, 16'd361, 8'd75}, {8'd30, 12'd50, 12'd322});
   endtask

   task automatic test_directed();
      esc_req_type rq;
      typical_trims();
      rq = '{20'd415148, 20'd519888, 16'd30000};
      send_reading(rq);
      rq = '{20'd0, 20'd0, 16'd0};
      send_reading(rq);
      rq = '{20'hfffff, 20'hfffff, 16'hffff};
      send_reading(rq);
      rq = '{20'h55555, 20'haaaaa, 16'h5555};
      send_reading(rq);
      rq = '{20'haaaaa, 20'h55555, 16'haaaa};
      send_reading(rq);
      drain_pipe();
      // zero trims: divisor zero
      load_trims('0, '0, '0, '0, '0, '0);
      rq = '{20'd400000, 20'd500000, 16'd30000};
      send_reading(rq);
      rq = '{20'hfffff, 20'hfffff, 16'hffff};
      send_reading(rq);
      drain_pipe();
      // all ones: extremes of every coefficient
      load_trims('1, '1, '1, '1, '1, '1);
      rq = '{20'd0, 20'hfffff, 16'd0};
      send_reading(rq);
      rq = '{20'hfffff, 20'd0, 16'hffff};
      send_reading(rq);
      drain_pipe();
      // huge T2 to saturate temperature both ways, strong humidity slope
      load_trims({16'h7fff, 16'h7fff, 16'h0000}, {16'h7fff, 16'h8000, 16'hffff},
                 {16'h8000, 16'h7fff, 16'h8000}, {16'h7fff, 16'h8000, 16'h7fff},
                 {8'hff, 16'h7fff, 8'hff}, {8'h7f, 12'h7ff, 12'h800});
      rq = '{20'd0, 20'hfffff, 16'hffff};
      send_reading(rq);
      rq = '{20'hfffff, 20'd0, 16'd0};
      send_reading(rq);
      rq = '{20'd100, 20'd70000, 16'h8000};
      send_reading(rq);
      drain_pipe();
      // out of range index is dropped
      csr_wr_en <= 1'b1;
      csr_index <= 3'd6;
      csr_wdata <= '1;
      @(posedge clock);
      csr_index <= 3'd7;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rq = '{20'd415148, 20'd519888, 16'd30000};
      send_reading(rq);
      drain_pipe();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph[0]) begin
            random_trims();
         end else begin
            typical_trims();
         end
         send_random(160);
         drain_pipe();
      end
   endtask

   task automatic test_no_idle();
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      typical_trims();
      send_random(200);
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      drain_pipe();
   endtask

   task automatic test_backpressure();
      random_trims();
      receiver_hold = 1'b1;
      send_random(200);
      // sender pauses until everything is back
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) begin
         @(posedge clock);
      end
      send_random(150);
      drain_pipe();
   endtask

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         idle_cycles <= 0;
      end else if (receiver_hold && idle_cycles < 300) begin
         rsp_ready   <= 1'b0;
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == 299) begin
            receiver_hold <= 1'b0;
         end
      end else begin
         idle_cycles <= 0;
         rsp_ready   <= !(receiver_idle_en && $urandom_range(99) < 25);
      end
   end

   always @(posedge clock) begin
      esc_rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result %p", rsp_data);
            end
         end else begin
            exp_r = expected_readings.pop_front();
            readings_checked++;
            if (exp_r.pressure_div_zero) begin
               div_zero_seen++;
            end
            if (rsp_data.temperature_centi !== exp_r.temperature_centi
                || rsp_data.pressure_pa !== exp_r.pressure_pa
                || rsp_data.pressure_div_zero !== exp_r.pressure_div_zero
                || rsp_data.humidity_q10 !== exp_r.humidity_q10) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: exp T=%0d P=%0d Z=%0d H=%0d got T=%0d P=%0d Z=%0d H=%0d",
                           exp_r.temperature_centi, exp_r.pressure_pa,
                           exp_r.pressure_div_zero, exp_r.humidity_q10,
                           rsp_data.temperature_centi, rsp_data.pressure_pa,
                           rsp_data.pressure_div_zero, rsp_data.humidity_q10);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= WDOG_LIMIT) begin
            $display("watchdog timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      trim_t           = '0;
      trim_pa          = '0;
      trim_pb          = '0;
      trim_pc          = '0;
      trim_ha          = '0;
      trim_hb          = '0;
      mismatch_count   = 0;
      readings_sent    = 0;
      readings_checked = 0;
      div_zero_seen    = 0;
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      receiver_hold    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_no_idle();
      test_backpressure();
      drain_pipe();
      $display("Sent %0d readings, checked %0d, %0d with zero pressure divisor.",
               readings_sent, readings_checked, div_zero_seen);
      $display("Covered extreme trims, saturation, long output stall and idle phases.");
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
